@@ rtl/led_matrix_frame_store_scanner_assert.svh @@
// Assertion helpers for the frame store scanner.
// Both sample on i_clk; the first is masked during reset.
`ifndef LED_MATRIX_FRAME_STORE_SCANNER_ASSERT_SVH
`define LED_MATRIX_FRAME_STORE_SCANNER_ASSERT_SVH

`define LMFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked through reset as well.
`define LMFS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/lmfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lmfs_pkg;

    localparam int GRID_SIZE = 8;
    localparam int COLOR_W   = 12;

    localparam logic [2:0] OP_SCAN = 3'd0;
    localparam logic [2:0] OP_DOT  = 3'd1;
    localparam logic [2:0] OP_FILL = 3'd2;
    localparam logic [2:0] OP_ROW  = 3'd3;
    localparam logic [2:0] OP_COL  = 3'd4;
    localparam logic [2:0] OP_DIAG = 3'd5;

    typedef logic [COLOR_W-1:0]           t_color;
    typedef t_color [GRID_SIZE-1:0]       t_row_pixels;
    typedef t_row_pixels [GRID_SIZE-1:0]  t_frame;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [3:0]  diag_index;
        logic        diag_dir;
        logic [11:0] color;
        logic        clear_others;
        logic [3:0]  level;
    } t_in_item;

    typedef struct packed {
        logic       is_scan;
        logic [2:0] scan_row;
        logic [7:0] green_mask;
        logic [7:0] red_mask;
        logic [7:0] blue_mask;
    } t_out_item;

    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
    } t_masks;

    typedef struct packed {
        logic        en;
        logic [2:0]  opcode;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [3:0]  diag_index;
        logic        diag_dir;
        logic [11:0] color;
        logic        clear;
    } t_paint_cmd;

endpackage

`default_nettype wire

@@ rtl/led_matrix_frame_store_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | valid       | ready       | payload
// ---------+-------------+-------------+----------------------
// command  | i_in_valid  | o_in_ready  | i_in_item  (t_in_item)
// result   | o_out_valid | i_out_ready | o_out_item (t_out_item)
//
// One command per cycle sustained while results are not stalled; result valid rises
// once the command has passed the input register, then paint/scan logic into the result register.
// The frame sits in flip-flops, so paints, fills and clears update the whole frame at once.
// Synchronous reset clears the frame and both valid flags.
// A stalled result holds the result register; the input register still
// takes one command, then ready drops until the result moves on.
module led_matrix_frame_store_scanner (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire lmfs_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output lmfs_pkg::t_out_item      o_out_item
);
    import lmfs_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    logic        advance;
    t_paint_cmd  paint_cmd;
    t_row_pixels rd_pixels;
    t_masks      masks;
    logic        paint_nonzero;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        paint_cmd.en         = r_in_valid && advance;
        paint_cmd.opcode     = r_in.opcode;
        paint_cmd.row        = r_in.row;
        paint_cmd.col        = r_in.col;
        paint_cmd.diag_index = r_in.diag_index;
        paint_cmd.diag_dir   = r_in.diag_dir;
        paint_cmd.color      = r_in.color;
        paint_cmd.clear      = r_in.clear_others;
    end

    lmfs_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (paint_cmd),
        .i_rd_row    (r_in.row),
        .o_rd_pixels (rd_pixels)
    );

    lmfs_scan u_scan (
        .i_pixels (rd_pixels),
        .i_level  (r_in.level),
        .o_masks  (masks)
    );

    always_comb begin
        n_out = '0;
        if (r_in.opcode == OP_SCAN) begin
            n_out.is_scan    = 1'b1;
            n_out.scan_row   = r_in.row;
            n_out.green_mask = masks.green;
            n_out.red_mask   = masks.red;
            n_out.blue_mask  = masks.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign paint_nonzero = !o_out_item.is_scan
                           && (o_out_item.scan_row != 3'd0
                               || o_out_item.green_mask != 8'd0
                               || o_out_item.red_mask != 8'd0
                               || o_out_item.blue_mask != 8'd0);

`include "led_matrix_frame_store_scanner_assert.svh"

    // paint results carry no row and no masks
    `LMFS_ASSERT(a_paint_zero, o_out_valid |-> !paint_nonzero, "paint result with nonzero fields")
    // a held command always reaches the result register once it may move
    `LMFS_ASSERT(a_advance, (r_in_valid && advance) |=> o_out_valid, "command lost between stages")
    // an empty result register never blocks the input side
    `LMFS_ASSERT(a_ready, !r_out_valid |-> o_in_ready, "input stalled with empty output")
    `LMFS_ASSERT_RST(a_reset, !i_rst_n |=> (!o_out_valid && !r_in_valid), "valid set after reset")

endmodule

`default_nettype wire

@@ rtl/lmfs_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none

// 8x8 frame in flip-flops: every cell decodes its own hit, one read row.
module lmfs_frame (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lmfs_pkg::t_paint_cmd i_cmd,
    input  wire logic [2:0]           i_rd_row,
    output lmfs_pkg::t_row_pixels     o_rd_pixels
);
    import lmfs_pkg::*;

    t_frame r_frame;
    t_frame n_frame;

    always_comb begin
        logic       paint;
        logic       hit;
        logic [4:0] lhs;
        logic [4:0] rhs;
        n_frame = r_frame;
        paint   = 1'b0;
        hit     = 1'b0;
        lhs     = '0;
        rhs     = '0;
        unique case (i_cmd.opcode)
            OP_DOT, OP_FILL, OP_ROW, OP_COL, OP_DIAG: paint = i_cmd.en;
            default:                                  paint = 1'b0;
        endcase
        if (paint) begin
            for (int r = 0; r < GRID_SIZE; r++) begin
                for (int c = 0; c < GRID_SIZE; c++) begin
                    // diag_dir set, main diagonal: col + 7 == d + row; clear: row + col == d; kept in 5 bits
                    if (i_cmd.diag_dir) begin
                        lhs = 5'(c + GRID_SIZE - 1);
                        rhs = {1'b0, i_cmd.diag_index} + 5'(r);
                    end else begin
                        lhs = 5'(r + c);
                        rhs = {1'b0, i_cmd.diag_index};
                    end
                    unique case (i_cmd.opcode)
                        OP_DOT:  hit = (i_cmd.row == 3'(r)) && (i_cmd.col == 3'(c));
                        OP_FILL: hit = 1'b1;
                        OP_ROW:  hit = (i_cmd.row == 3'(r));
                        OP_COL:  hit = (i_cmd.col == 3'(c));
                        OP_DIAG: hit = (lhs == rhs);
                        default: hit = 1'b0;
                    endcase
                    if (i_cmd.clear) begin
                        n_frame[r][c] = '0;
                    end
                    if (hit) begin
                        n_frame[r][c] = i_cmd.color;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else begin
            r_frame <= n_frame;
        end
    end

    assign o_rd_pixels = r_frame[i_rd_row];

endmodule

`default_nettype wire

@@ rtl/lmfs_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

// PWM compare: a column's bit is set when its nibble exceeds the level.
module lmfs_scan (
    input  wire lmfs_pkg::t_row_pixels i_pixels,
    input  wire logic [3:0]            i_level,
    output lmfs_pkg::t_masks           o_masks
);
    import lmfs_pkg::*;

    always_comb begin
        o_masks = '0;
        for (int c = 0; c < GRID_SIZE; c++) begin
            o_masks.red[c]   = i_pixels[c][3:0]  > i_level;
            o_masks.green[c] = i_pixels[c][7:4]  > i_level;
            o_masks.blue[c]  = i_pixels[c][11:8] > i_level;
        end
    end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import lmfs_pkg::*;

    // opcodes the block must ignore
    localparam logic [2:0] OP_UNUSED6 = 3'd6;
    localparam logic [2:0] OP_UNUSED7 = 3'd7;

    localparam int RANDOM_CMDS = 1800;
    localparam int DRAIN_CYCLES = 8;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_ready = 1'b1;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    t_in_item  cmd_q[$];
    t_out_item expected_q[$];
    t_frame    frame_model = '0;
    int        total_cmds = 0;
    int        accepted_cmds = 0;
    int        error_count = 0;

    led_matrix_frame_store_scanner uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic t_in_item make_cmd(logic [2:0] op, logic [2:0] row, logic [2:0] col,
                                          logic [3:0] d, logic dir, logic [11:0] color,
                                          logic clr, logic [3:0] level);
        t_in_item c;
        c.opcode       = op;
        c.row          = row;
        c.col          = col;
        c.diag_index   = d;
        c.diag_dir     = dir;
        c.color        = color;
        c.clear_others = clr;
        c.level        = level;
        return c;
    endfunction

    function automatic t_in_item random_cmd();
        t_in_item    c;
        int          pick;
        logic [31:0] rnd;
        rnd = $urandom;
        c = rnd[$bits(t_in_item)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 40)      c.opcode = OP_SCAN;
        else if (pick < 58) c.opcode = OP_DOT;
        else if (pick < 62) c.opcode = OP_FILL;
        else if (pick < 73) c.opcode = OP_ROW;
        else if (pick < 84) c.opcode = OP_COL;
        else if (pick < 97) c.opcode = OP_DIAG;
        else                c.opcode = ($urandom_range(0, 1) != 0) ? OP_UNUSED6 : OP_UNUSED7;
        // rare clears so the frame fills up with overlapping paints
        c.clear_others = ($urandom_range(0, 19) == 0);
        return c;
    endfunction

    // Updates the frame copy and queues the result the block should return.
    task automatic apply_command(input t_in_item cmd);
        t_out_item res;
        t_color    px;
        logic      hit;
        int        d;
        res = '0;
        d = int'(cmd.diag_index);
        if (cmd.opcode == OP_SCAN) begin
            res.is_scan  = 1'b1;
            res.scan_row = cmd.row;
            for (int c = 0; c < GRID_SIZE; c++) begin
                px = frame_model[cmd.row][c];
                res.red_mask[c]   = px[3:0] > cmd.level;
                res.green_mask[c] = px[7:4] > cmd.level;
                res.blue_mask[c]  = px[11:8] > cmd.level;
            end
        end else if (cmd.opcode <= OP_DIAG) begin
            if (cmd.clear_others)
                frame_model = '0;
            for (int r = 0; r < GRID_SIZE; r++) begin
                for (int c = 0; c < GRID_SIZE; c++) begin
                    case (cmd.opcode)
                        OP_DOT:  hit = (r == int'(cmd.row)) && (c == int'(cmd.col));
                        OP_FILL: hit = 1'b1;
                        OP_ROW:  hit = (r == int'(cmd.row));
                        OP_COL:  hit = (c == int'(cmd.col));
                        default: hit = cmd.diag_dir ? (c + 7 == d + r) : (r + c == d);
                    endcase
                    if (hit)
                        frame_model[r][c] = cmd.color;
                end
            end
        end
        expected_q.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
        if (exp !== act) begin
            $error("%s: expected %h, actual %h", name, exp, act);
            error_count++;
        end
    endtask

    // Command driver: bursts of back-to-back transfers separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                apply_command(in_item);
                accepted_cmds++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    in_item  <= cmd_q.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: ready pattern switches between always, coin flip and mostly stalled.
    int stall_mode = 0;
    int stall_mode_left = 0;

    always @(posedge clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(16, 200);
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Result monitor
    always @(posedge clk) begin
        t_out_item exp;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer: %h", out_item);
                error_count++;
            end else begin
                exp = expected_q.pop_front();
                check_field("is_scan", 8'(exp.is_scan), 8'(out_item.is_scan));
                check_field("scan_row", 8'(exp.scan_row), 8'(out_item.scan_row));
                check_field("green_mask", exp.green_mask, out_item.green_mask);
                check_field("red_mask", exp.red_mask, out_item.red_mask);
                check_field("blue_mask", exp.blue_mask, out_item.blue_mask);
            end
        end
    end

    initial begin
        // directed: empty frame, extremes of level, every paint shape, ignored opcodes
        cmd_q.push_back(make_cmd(OP_SCAN, 3'd0, 3'd0, 4'd0, 1'b0, 12'h000, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_FILL, 3'd0, 3'd0, 4'd0, 1'b0, 12'hFFF, 1'b1, 4'd0));
        cmd_q.push_back(make_cmd(OP_SCAN, 3'd7, 3'd0, 4'd0, 1'b0, 12'hFFF, 1'b1, 4'd0));
        cmd_q.push_back(make_cmd(OP_SCAN, 3'd7, 3'd0, 4'd0, 1'b0, 12'h000, 1'b0, 4'd15));
        cmd_q.push_back(make_cmd(OP_SCAN, 3'd3, 3'd0, 4'd0, 1'b0, 12'h000, 1'b0, 4'd14));
        cmd_q.push_back(make_cmd(OP_DOT, 3'd0, 3'd0, 4'd0, 1'b0, 12'h123, 1'b1, 4'd0));
        cmd_q.push_back(make_cmd(OP_DOT, 3'd7, 3'd7, 4'd15, 1'b1, 12'hFFF, 1'b0, 4'd15));
        cmd_q.push_back(make_cmd(OP_SCAN, 3'd0, 3'd0, 4'd0, 1'b0, 12'h000, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_SCAN, 3'd7, 3'd0, 4'd0, 1'b0, 12'h000, 1'b0, 4'd14));
        cmd_q.push_back(make_cmd(OP_ROW, 3'd3, 3'd0, 4'd0, 1'b0, 12'hA5C, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_COL, 3'd0, 3'd4, 4'd0, 1'b0, 12'h5A3, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_SCAN, 3'd3, 3'd0, 4'd0, 1'b0, 12'hFFF, 1'b1, 4'd4));
        cmd_q.push_back(make_cmd(OP_DIAG, 3'd0, 3'd0, 4'd0, 1'b0, 12'h8F1, 1'b1, 4'd0));
        cmd_q.push_back(make_cmd(OP_DIAG, 3'd0, 3'd0, 4'd14, 1'b0, 12'h1F8, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_DIAG, 3'd0, 3'd0, 4'd7, 1'b0, 12'hF00, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_DIAG, 3'd0, 3'd0, 4'd0, 1'b1, 12'h0F0, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_DIAG, 3'd0, 3'd0, 4'd14, 1'b1, 12'h00F, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_DIAG, 3'd0, 3'd0, 4'd7, 1'b1, 12'h777, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_SCAN, 3'd0, 3'd0, 4'd0, 1'b0, 12'h000, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_SCAN, 3'd7, 3'd0, 4'd0, 1'b0, 12'h000, 1'b0, 4'd0));
        // diagonal fifteen paints nothing, but the clear still happens
        cmd_q.push_back(make_cmd(OP_DIAG, 3'd0, 3'd0, 4'd15, 1'b0, 12'hFFF, 1'b1, 4'd0));
        cmd_q.push_back(make_cmd(OP_DIAG, 3'd0, 3'd0, 4'd15, 1'b1, 12'hFFF, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_SCAN, 3'd4, 3'd0, 4'd0, 1'b0, 12'h000, 1'b0, 4'd0));
        cmd_q.push_back(make_cmd(OP_UNUSED6, 3'd7, 3'd7, 4'd15, 1'b1, 12'hFFF, 1'b1, 4'd15));
        cmd_q.push_back(make_cmd(OP_UNUSED7, 3'd2, 3'd5, 4'd3, 1'b0, 12'hABC, 1'b1, 4'd9));
        cmd_q.push_back(make_cmd(OP_FILL, 3'd1, 3'd6, 4'd9, 1'b1, 12'h9C3, 1'b0, 4'd2));
        for (int i = 0; i < RANDOM_CMDS; i++)
            cmd_q.push_back(random_cmd());
        total_cmds = cmd_q.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cmds < total_cmds || expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lmfs_pkg.sv
rtl/lmfs_frame.sv
rtl/lmfs_scan.sv
rtl/led_matrix_frame_store_scanner.sv
verif/tb.sv
